// ===== src/tasd_pkg.sv =====
// Shared types and constants for the three-axis step distributor.
`timescale 1ns / 1ps

package tasd_pkg;

  localparam int unsigned DELTA_BITS_DEF    = 16;
  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned OUT_POS_BITS      = 32;

  // Item kinds carried on func
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_ZERO = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       setup;
    logic       div_step;
    logic       commit;
    logic [1:0] func;
  } dcmd_t;

endpackage

// ===== src/tasd_ctrl.sv =====
// Controller: sequences capture, divide and commit of each item.
`timescale 1ns / 1ps

module tasd_ctrl #(
  parameter int unsigned DivSteps = tasd_pkg::DELTA_BITS_DEF - 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tasd_pkg::dcmd_t   cmd_o
);
  import tasd_pkg::*;

  localparam int unsigned CntW = $clog2(DivSteps);
  localparam logic [CntW-1:0] CntLast = CntW'(DivSteps - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [1:0]      func_q, func_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            in_fire;
  logic            out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    func_d         = func_q;
    cnt_d          = cnt_q;
    cmd_o.capture  = 1'b0;
    cmd_o.setup    = 1'b0;
    cmd_o.div_step = 1'b0;
    cmd_o.commit   = 1'b0;
    cmd_o.func     = func_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_fire;
        if (in_fire) begin
          func_d  = func_i;
          state_d = (func_i == FUNC_LOAD) ? S_SETUP : S_FIN;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        cnt_d       = '0;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output beat slot is free
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= FUNC_LOAD;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> out_free)
    else $error("commit while output beat still pending");

  a_load_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && func_i == FUNC_LOAD) |=> (state_q == S_SETUP))
    else $error("load did not enter setup");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == CntLast) |=> (state_q == S_FIN))
    else $error("divide did not finish after its last step");
`endif

endmodule

// ===== src/tasd_dpath.sv =====
// Datapath: magnitudes, major axis pick, two restoring dividers, tick pacing, positions.
`timescale 1ns / 1ps

module tasd_dpath #(
  parameter int unsigned DeltaBits    = tasd_pkg::DELTA_BITS_DEF,
  parameter int unsigned PositionBits = tasd_pkg::POSITION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tasd_pkg::dcmd_t                       cmd_i,
  input  logic signed [DeltaBits-1:0]           delta_a_i,
  input  logic signed [DeltaBits-1:0]           delta_b_i,
  input  logic signed [DeltaBits-1:0]           delta_c_i,
  output logic [2:0]                            step_mask_o,
  output logic [2:0]                            dir_mask_o,
  output logic                                  last_step_o,
  output logic                                  busy_res_o,
  output logic signed [tasd_pkg::OUT_POS_BITS-1:0] pos_a_o,
  output logic signed [tasd_pkg::OUT_POS_BITS-1:0] pos_b_o,
  output logic signed [tasd_pkg::OUT_POS_BITS-1:0] pos_c_o
);
  import tasd_pkg::*;

  localparam int unsigned MagW = DeltaBits - 1;
  localparam int unsigned CntW = DeltaBits;

  localparam logic [1:0] AXIS_A = 2'd0;
  localparam logic [1:0] AXIS_B = 2'd1;
  localparam logic [1:0] AXIS_C = 2'd2;

  // captured segment deltas
  logic signed [DeltaBits-1:0] delta_q [3];

  // segment state
  logic [1:0]      maj_ax_q, mn1_ax_q, mn2_ax_q;
  logic [2:0]      dir_q;
  logic [MagW-1:0] major_q;
  logic [CntW-1:0] tick_q;
  logic [CntW-1:0] tgt_q [2];

  // divider lanes; quo holds the quotient after the last step
  logic [MagW-1:0] quo_q [2];
  logic [MagW:0]   rem_q [2];
  logic [MagW-1:0] dvs_q [2];

  logic signed [PositionBits-1:0] pos_q [3];

  // output beat
  logic [2:0]                   step_q, dir_out_q;
  logic                         last_q, busy_q;
  logic signed [OUT_POS_BITS-1:0] pos_out_q [3];

  // setup logic
  logic [MagW-1:0]      mag [3];
  logic [2:0]           neg;
  logic [DeltaBits-1:0] negv [3];
  logic [1:0]           maj_ax, mn1_ax, mn2_ax;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i]  = delta_q[i][DeltaBits-1];
      negv[i] = '0 - delta_q[i];
      if (neg[i]) begin
        // most negative value saturates
        mag[i] = negv[i][DeltaBits-1] ? {MagW{1'b1}} : negv[i][MagW-1:0];
      end else if (delta_q[i] == '0) begin
        mag[i] = MagW'(1);
      end else begin
        mag[i] = delta_q[i][MagW-1:0];
      end
    end
    if (mag[0] > mag[1]) begin
      maj_ax = (mag[0] > mag[2]) ? AXIS_A : AXIS_C;
    end else begin
      maj_ax = (mag[1] > mag[2]) ? AXIS_B : AXIS_C;
    end
    case (maj_ax)
      AXIS_A: begin
        mn1_ax = AXIS_C;
        mn2_ax = AXIS_B;
      end
      AXIS_B: begin
        mn1_ax = AXIS_A;
        mn2_ax = AXIS_C;
      end
      default: begin
        mn1_ax = AXIS_A;
        mn2_ax = AXIS_B;
      end
    endcase
  end

  // divider step
  logic [MagW:0]   rem_sh [2];
  logic [MagW:0]   rem_nx [2];
  logic [MagW-1:0] quo_nx [2];
  logic            q_bit  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_sh[l] = {rem_q[l][MagW-1:0], quo_q[l][MagW-1]};
      q_bit[l]  = (rem_sh[l] >= {1'b0, dvs_q[l]});
      rem_nx[l] = q_bit[l] ? (rem_sh[l] - {1'b0, dvs_q[l]}) : rem_sh[l];
      quo_nx[l] = {quo_q[l][MagW-2:0], q_bit[l]};
    end
  end

  // commit logic
  logic                           is_tick, is_load, is_zero;
  logic                           active, fire_maj;
  logic [1:0]                     fire_mn;
  logic [2:0]                     step_v;
  logic [CntW-1:0]                tick_d;
  logic [CntW-1:0]                tgt_d [2];
  logic                           busy_d, last_d;
  logic signed [PositionBits-1:0] pos_d [3];

  always_comb begin
    is_tick  = (cmd_i.func == FUNC_TICK);
    is_load  = (cmd_i.func == FUNC_LOAD);
    is_zero  = (cmd_i.func == FUNC_ZERO);
    active   = (tick_q <= {1'b0, major_q});
    fire_maj = is_tick && active;
    for (int l = 0; l < 2; l++) begin
      fire_mn[l] = fire_maj && (tick_q == tgt_q[l]);
      if (is_load) begin
        tgt_d[l] = {1'b0, quo_q[l]};
      end else if (fire_mn[l]) begin
        tgt_d[l] = tgt_q[l] + {1'b0, quo_q[l]};
      end else begin
        tgt_d[l] = tgt_q[l];
      end
    end
    step_v = '0;
    if (fire_maj)   step_v[maj_ax_q] = 1'b1;
    if (fire_mn[0]) step_v[mn1_ax_q] = 1'b1;
    if (fire_mn[1]) step_v[mn2_ax_q] = 1'b1;
    last_d = fire_maj && (tick_q == {1'b0, major_q});
    if (is_load) begin
      tick_d = CntW'(1);
    end else if (fire_maj) begin
      tick_d = tick_q + 1'b1;
    end else begin
      tick_d = tick_q;
    end
    busy_d = (tick_d <= {1'b0, major_q});
    for (int i = 0; i < 3; i++) begin
      if (is_zero) begin
        pos_d[i] = '0;
      end else if (step_v[i]) begin
        pos_d[i] = dir_q[i] ? (pos_q[i] - 1'b1) : (pos_q[i] + 1'b1);
      end else begin
        pos_d[i] = pos_q[i];
      end
    end
  end

  // capture and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      delta_q[0] <= delta_a_i;
      delta_q[1] <= delta_b_i;
      delta_q[2] <= delta_c_i;
    end
    if (cmd_i.setup) begin
      quo_q[0] <= mag[maj_ax];
      quo_q[1] <= mag[maj_ax];
      rem_q[0] <= '0;
      rem_q[1] <= '0;
      dvs_q[0] <= mag[mn1_ax];
      dvs_q[1] <= mag[mn2_ax];
    end else if (cmd_i.div_step) begin
      for (int l = 0; l < 2; l++) begin
        quo_q[l] <= quo_nx[l];
        rem_q[l] <= rem_nx[l];
      end
    end
  end

  // segment state and positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maj_ax_q <= AXIS_A;
      mn1_ax_q <= AXIS_A;
      mn2_ax_q <= AXIS_A;
      dir_q    <= '0;
      major_q  <= '0;
      tick_q   <= CntW'(1);
      tgt_q[0] <= '0;
      tgt_q[1] <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
      end
    end else if (cmd_i.setup) begin
      maj_ax_q <= maj_ax;
      mn1_ax_q <= mn1_ax;
      mn2_ax_q <= mn2_ax;
      dir_q    <= neg;
      major_q  <= mag[maj_ax];
      tick_q   <= CntW'(1);
    end else if (cmd_i.commit) begin
      tick_q   <= tick_d;
      tgt_q[0] <= tgt_d[0];
      tgt_q[1] <= tgt_d[1];
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= pos_d[i];
      end
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      step_q    <= step_v;
      dir_out_q <= dir_q;
      last_q    <= last_d;
      busy_q    <= busy_d;
      for (int i = 0; i < 3; i++) begin
        pos_out_q[i] <= OUT_POS_BITS'(pos_d[i]);
      end
    end
  end

  assign step_mask_o = step_q;
  assign dir_mask_o  = dir_out_q;
  assign last_step_o = last_q;
  assign busy_res_o  = busy_q;
  assign pos_a_o     = pos_out_q[0];
  assign pos_b_o     = pos_out_q[1];
  assign pos_c_o     = pos_out_q[2];

`ifndef NO_ASSERTIONS
  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q <= ({1'b0, major_q} + 1'b1))
    else $error("tick counter ran past the major count");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> !(last_q && busy_q))
    else $error("last step reported while still busy");

  a_step_major: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !fire_maj) |-> (step_v == 3'b000))
    else $error("minor axis stepped without a major step");
`endif

endmodule

// ===== src/three_axis_step_distributor_core.sv =====
// Top level of the three-axis step distributor.
`timescale 1ns / 1ps

// Three-axis step distributor. A load beat (func 0) takes three signed step
// deltas, picks the axis with the most steps as major and divides its count
// by each minor count; a tick beat (func 1) then steps the major axis and any
// minor axis whose pacing point is reached, and a zero beat (func 2) clears
// all positions. Every input beat gives exactly one result beat with the step
// and direction masks, segment status and the three positions. Tick, zero and
// unused beats pass the finish state before the next accept. A load also
// passes setup and the divide steps first: the two restoring dividers
// produce one quotient bit per cycle. A result waiting on out_ready_i does not
// block acceptance of the next input beat, only its completion.
module three_axis_step_distributor_core #(
  parameter int unsigned DELTA_BITS    = tasd_pkg::DELTA_BITS_DEF,
  parameter int unsigned POSITION_BITS = tasd_pkg::POSITION_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [1:0]                               func_i,
  input  logic signed [DELTA_BITS-1:0]             delta_a_i,
  input  logic signed [DELTA_BITS-1:0]             delta_b_i,
  input  logic signed [DELTA_BITS-1:0]             delta_c_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [2:0]                               step_mask_o,
  output logic [2:0]                               dir_mask_o,
  output logic                                     last_step_o,
  output logic                                     busy_res_o,
  output logic signed [tasd_pkg::OUT_POS_BITS-1:0] pos_a_o,
  output logic signed [tasd_pkg::OUT_POS_BITS-1:0] pos_b_o,
  output logic signed [tasd_pkg::OUT_POS_BITS-1:0] pos_c_o
);
  import tasd_pkg::*;

  dcmd_t cmd;

  tasd_ctrl #(
    .DivSteps (DELTA_BITS - 1)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tasd_dpath #(
    .DeltaBits    (DELTA_BITS),
    .PositionBits (POSITION_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .delta_a_i   (delta_a_i),
    .delta_b_i   (delta_b_i),
    .delta_c_i   (delta_c_i),
    .step_mask_o (step_mask_o),
    .dir_mask_o  (dir_mask_o),
    .last_step_o (last_step_o),
    .busy_res_o  (busy_res_o),
    .pos_a_o     (pos_a_o),
    .pos_b_o     (pos_b_o),
    .pos_c_o     (pos_c_o)
  );

endmodule

// ===== sim/three_axis_step_distributor_core_tb.sv =====
// Self-checking testbench for the three-axis step distributor core.
`timescale 1ns / 1ps

module three_axis_step_distributor_core_tb;
  import tasd_pkg::*;

  localparam int DW = DELTA_BITS_DEF;
  localparam int unsigned MAG_CAP = (1 << (DW - 1)) - 1;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 200;
  localparam int RANDOM_BEATS = 1000;

  typedef struct packed {
    logic [2:0]  step;
    logic [2:0]  dir;
    logic        last;
    logic        busy;
    logic [31:0] pa;
    logic [31:0] pb;
    logic [31:0] pc;
  } axis_report_t;

  typedef struct packed {
    logic [1:0]    func;
    logic [DW-1:0] da;
    logic [DW-1:0] db;
    logic [DW-1:0] dc;
    logic          typed;
    axis_report_t  want;
  } stim_row_t;

  localparam axis_report_t NO_REPORT = '0;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           func_i = FUNC_TICK;
  logic signed [DW-1:0] delta_a_i = '0;
  logic signed [DW-1:0] delta_b_i = '0;
  logic signed [DW-1:0] delta_c_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [2:0]           step_mask_o;
  logic [2:0]           dir_mask_o;
  logic                 last_step_o;
  logic                 busy_res_o;
  logic signed [31:0]   pos_a_o;
  logic signed [31:0]   pos_b_o;
  logic signed [31:0]   pos_c_o;

  always #6 clk_i = ~clk_i;

  three_axis_step_distributor_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .delta_a_i   (delta_a_i),
    .delta_b_i   (delta_b_i),
    .delta_c_i   (delta_c_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .step_mask_o (step_mask_o),
    .dir_mask_o  (dir_mask_o),
    .last_step_o (last_step_o),
    .busy_res_o  (busy_res_o),
    .pos_a_o     (pos_a_o),
    .pos_b_o     (pos_b_o),
    .pos_c_o     (pos_c_o)
  );

  // Predicted segment state
  logic [1:0]  maj_ax, min1_ax, min2_ax;
  logic [14:0] seg_len, div1, div2;
  logic [15:0] tick_no, mult1, mult2;
  logic [2:0]  dir_bits;
  logic [31:0] axis_pos [3];

  axis_report_t expected_reports [$];
  int           errs = 0;
  int           beats_sent = 0;
  int           reports_seen = 0;
  bit           tx_no_gaps = 1'b0;
  bit           rx_no_stall = 1'b0;

  stim_row_t plan [25] = '{
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0}},
    '{FUNC_SPARE, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0}},
    '{FUNC_ZERO,  16'sd0, 16'sd0, 16'sd0, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0}},
    '{FUNC_LOAD,  16'sd1, 16'sd0, -16'sd1,
      1'b1, '{3'd0, 3'b100, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0}},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0,
      1'b1, '{3'b111, 3'b100, 1'b1, 1'b0, 32'd1, 32'd1, 32'hFFFF_FFFF}},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0,
      1'b1, '{3'd0, 3'b100, 1'b0, 1'b0, 32'd1, 32'd1, 32'hFFFF_FFFF}},
    '{FUNC_ZERO,  16'sd0, 16'sd0, 16'sd0,
      1'b1, '{3'd0, 3'b100, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0}},
    // most negative delta saturates, zero delta counts as one step forward
    '{FUNC_LOAD,  16'sh8000, 16'sh7FFF, 16'sd0,
      1'b1, '{3'd0, 3'b001, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0}},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    // replace the running segment
    '{FUNC_LOAD,  16'sd5, -16'sd3, 16'sd2, 1'b0, NO_REPORT},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_LOAD,  -16'sd32767, 16'sd100, -16'sd32767, 1'b0, NO_REPORT},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_SPARE, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_ZERO,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT},
    '{FUNC_LOAD,  -16'sd1, -16'sd1, -16'sd1, 1'b0, NO_REPORT},
    '{FUNC_TICK,  16'sd0, 16'sd0, 16'sd0, 1'b0, NO_REPORT}
  };

  function automatic int unsigned delta_mag(logic signed [DW-1:0] d);
    int v;
    v = d;
    if (v < 0) v = -v;
    else if (v == 0) v = 1;
    if (v > int'(MAG_CAP)) v = MAG_CAP;
    return v;
  endfunction

  function automatic void move_axis(logic [1:0] ax);
    axis_pos[ax] = dir_bits[ax] ? axis_pos[ax] - 32'd1 : axis_pos[ax] + 32'd1;
  endfunction

  // Advance the predicted state by one beat and return the report it yields.
  function automatic axis_report_t predict_motion(logic [1:0] f, logic signed [DW-1:0] da,
                                                  logic signed [DW-1:0] db,
                                                  logic signed [DW-1:0] dc);
    int unsigned m [3];
    logic signed [DW-1:0] d [3];
    axis_report_t r;
    d[0] = da;
    d[1] = db;
    d[2] = dc;
    r = '0;
    case (f)
      FUNC_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          m[i] = delta_mag(d[i]);
          dir_bits[i] = d[i][DW-1];
        end
        if (m[0] > m[1]) begin
          if (m[0] > m[2]) {maj_ax, min1_ax, min2_ax} = {2'd0, 2'd2, 2'd1};
          else {maj_ax, min1_ax, min2_ax} = {2'd2, 2'd0, 2'd1};
        end else if (m[1] > m[2]) begin
          {maj_ax, min1_ax, min2_ax} = {2'd1, 2'd0, 2'd2};
        end else begin
          {maj_ax, min1_ax, min2_ax} = {2'd2, 2'd0, 2'd1};
        end
        seg_len = 15'(m[maj_ax]);
        div1 = 15'(m[maj_ax] / m[min1_ax]);
        div2 = 15'(m[maj_ax] / m[min2_ax]);
        tick_no = 16'd1;
        mult1 = 16'd1;
        mult2 = 16'd1;
      end
      FUNC_TICK: begin
        if (tick_no <= {1'b0, seg_len}) begin
          move_axis(maj_ax);
          r.step[maj_ax] = 1'b1;
          if (32'(tick_no) == 32'(div1) * 32'(mult1)) begin
            move_axis(min1_ax);
            r.step[min1_ax] = 1'b1;
            mult1++;
          end
          if (32'(tick_no) == 32'(div2) * 32'(mult2)) begin
            move_axis(min2_ax);
            r.step[min2_ax] = 1'b1;
            mult2++;
          end
          r.last = (tick_no == {1'b0, seg_len});
          tick_no++;
        end
      end
      FUNC_ZERO: begin
        axis_pos = '{32'd0, 32'd0, 32'd0};
      end
      default: ;
    endcase
    r.dir = dir_bits;
    r.busy = (tick_no <= {1'b0, seg_len});
    r.pa = axis_pos[0];
    r.pb = axis_pos[1];
    r.pc = axis_pos[2];
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_delta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return DW'($urandom_range(0, 40)) - DW'(20);
    if (r < 88) return DW'($urandom);
    case ($urandom_range(0, 5))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return {1'b1, {(DW-2){1'b0}}, 1'b1};
      default: return DW'(1);
    endcase
  endfunction

  // Offer one beat, wait for its acceptance, then queue what it should produce.
  task automatic send_beat(logic [1:0] f, logic signed [DW-1:0] da, logic signed [DW-1:0] db,
                           logic signed [DW-1:0] dc, logic typed, axis_report_t want);
    int gap;
    axis_report_t guess;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    delta_a_i <= da;
    delta_b_i <= db;
    delta_c_i <= dc;
    do @(posedge clk_i); while (!in_ready_o);
    guess = predict_motion(f, da, db, dc);
    expected_reports.push_back(typed ? want : guess);
    beats_sent++;
  endtask

  initial begin
    maj_ax = '0;
    min1_ax = '0;
    min2_ax = '0;
    seg_len = '0;
    div1 = '0;
    div2 = '0;
    tick_no = 16'd1;
    mult1 = 16'd1;
    mult2 = 16'd1;
    dir_bits = '0;
    axis_pos = '{32'd0, 32'd0, 32'd0};
  end

  // Stimulus: directed table first, then random segments
  initial begin
    int unsigned r, n, longest;
    logic signed [DW-1:0] a, b, c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (plan[k]) begin
      send_beat(plan[k].func, plan[k].da, plan[k].db, plan[k].dc, plan[k].typed, plan[k].want);
    end
    while (beats_sent < $size(plan) + RANDOM_BEATS) begin
      tx_no_gaps = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        a = rand_delta();
        b = rand_delta();
        c = rand_delta();
        send_beat(FUNC_LOAD, a, b, c, 1'b0, NO_REPORT);
        longest = delta_mag(a);
        if (delta_mag(b) > longest) longest = delta_mag(b);
        if (delta_mag(c) > longest) longest = delta_mag(c);
        n = (longest > 40 ? 40 : longest) + $urandom_range(0, 2);
        repeat (n) begin
          if ($urandom_range(0, 29) == 0) begin
            send_beat($urandom_range(0, 1) ? FUNC_ZERO : FUNC_SPARE,
                      rand_delta(), rand_delta(), rand_delta(), 1'b0, NO_REPORT);
          end
          send_beat(FUNC_TICK, rand_delta(), rand_delta(), rand_delta(), 1'b0, NO_REPORT);
        end
      end else begin
        case ($urandom_range(0, 3))
          0: send_beat(FUNC_ZERO, rand_delta(), rand_delta(), rand_delta(), 1'b0, NO_REPORT);
          1: send_beat(FUNC_SPARE, rand_delta(), rand_delta(), rand_delta(), 1'b0, NO_REPORT);
          2: send_beat(FUNC_TICK, rand_delta(), rand_delta(), rand_delta(), 1'b0, NO_REPORT);
          default: begin
            // abandon a fresh segment after up to three ticks
            send_beat(FUNC_LOAD, rand_delta(), rand_delta(), rand_delta(), 1'b0, NO_REPORT);
            repeat ($urandom_range(0, 3)) begin
              send_beat(FUNC_TICK, rand_delta(), rand_delta(), rand_delta(), 1'b0, NO_REPORT);
            end
          end
        endcase
      end
    end
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off to back up the input
  initial begin
    int stall;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (!hold_done && reports_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if ($urandom_range(0, 15) == 0) rx_no_stall = ($urandom_range(0, 2) == 0);
      stall = rx_no_stall ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    axis_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $error("result beat with no pending expectation");
        errs++;
      end else begin
        want = expected_reports.pop_front();
        if (step_mask_o !== want.step) begin
          $error("step_mask: expected %0b, got %0b", want.step, step_mask_o);
          errs++;
        end
        if (dir_mask_o !== want.dir) begin
          $error("dir_mask: expected %0b, got %0b", want.dir, dir_mask_o);
          errs++;
        end
        if (last_step_o !== want.last) begin
          $error("last_step: expected %0d, got %0d", want.last, last_step_o);
          errs++;
        end
        if (busy_res_o !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, busy_res_o);
          errs++;
        end
        if (pos_a_o !== want.pa) begin
          $error("pos_a: expected %0d, got %0d", $signed(want.pa), pos_a_o);
          errs++;
        end
        if (pos_b_o !== want.pb) begin
          $error("pos_b: expected %0d, got %0d", $signed(want.pb), pos_b_o);
          errs++;
        end
        if (pos_c_o !== want.pc) begin
          $error("pos_c: expected %0d, got %0d", $signed(want.pc), pos_c_o);
          errs++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat moving on either side
  always @(posedge clk_i) begin
    int quiet;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
